// ----- rtl/core/cmg_pkg.sv -----
`default_nettype none

package cmg_pkg;

    localparam int MATRIX_ENTRIES = 9;
    localparam int TERMS          = 4;
    localparam int HORNER_STEPS   = TERMS - 1;
    localparam int DIV_STEPS      = 8;

    // Pipeline stage map
    localparam int ST_READ      = 0;
    localparam int ST_HORNER    = 1;
    localparam int ST_ONE_MINUS = ST_HORNER + 2 * HORNER_STEPS;
    localparam int ST_DIV_FIRST = ST_ONE_MINUS + 1;
    localparam int ST_SCALE_MUL = ST_DIV_FIRST + DIV_STEPS;
    localparam int ST_SCALE_REM = ST_SCALE_MUL + 1;
    localparam int ST_SCALE_SUM = ST_SCALE_REM + 1;
    localparam int ST_SELECT    = ST_SCALE_SUM + 1;
    localparam int ST_OUT       = ST_SELECT + 1;
    localparam int PIPE_DEPTH   = ST_OUT + 1;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    localparam logic CFG_NATIVE_D65    = 1'b0;
    localparam logic CFG_NATIVE_NORMAL = 1'b1;

    localparam logic [13:0] NATIVE_D65_RST    = 14'd6500;
    localparam logic [13:0] NATIVE_NORMAL_RST = 14'd7500;

    localparam logic [63:0] Q47_ONE = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic        fade;
        logic [13:0] x;
        logic [7:0]  s;
    } ctl_t;

    // Sign and magnitude with a sticky saturation flag
    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
        logic        sat;
    } sm_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } q_t;

    function automatic sm_t sm_of(input logic [63:0] v);
        sm_t r;
        r.neg = v[63];
        r.mag = v[63] ? (~v + 64'd1) : v;
        r.sat = 1'b0;
        return r;
    endfunction

    function automatic logic [63:0] sm_val(input sm_t s);
        return s.neg ? (~s.mag + 64'd1) : s.mag;
    endfunction

    // Clamp a sign and magnitude to the signed 64 bit range
    function automatic sm_t sm_clamp(input logic neg, input logic [64:0] mag);
        sm_t r;
        r.sat = 1'b0;
        if (!neg) begin
            r.neg = 1'b0;
            if (mag > {2'b00, {63{1'b1}}}) begin
                r.sat = 1'b1;
                r.mag = {1'b0, {63{1'b1}}};
            end else begin
                r.mag = mag[63:0];
            end
        end else begin
            if (mag > {2'b01, 63'd0}) begin
                r.sat = 1'b1;
                r.mag = {1'b1, 63'd0};
            end else begin
                r.mag = mag[63:0];
            end
            r.neg = (r.mag != 64'd0);
        end
        return r;
    endfunction

    // Signed add of two sign and magnitude values, saturating
    function automatic sm_t sm_add(input logic pn, input logic [63:0] pm,
                                   input logic cn, input logic [63:0] cm);
        sm_t r;
        logic pn2;
        pn2 = pn && (pm != 64'd0);
        if (pn2 == cn) begin
            r = sm_clamp(pn2, {1'b0, pm} + {1'b0, cm});
        end else if (pm >= cm) begin
            r = sm_clamp(pn2, {1'b0, pm - cm});
        end else begin
            r = sm_clamp(cn, {1'b0, cm - pm});
        end
        return r;
    endfunction

    // Q16.47 to Q2.30 with rounding and saturation
    function automatic q_t to_q230(input logic [63:0] v);
        q_t r;
        logic [63:0] w;
        logic signed [63:0] f;
        r.sat = 1'b0;
        w = v + 64'd65536;
        f = $signed(w) >>> 17;
        if ($signed(v) > $signed(64'h7FFF_FFFF_FFFE_FFFF)) begin
            r.sat = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end else if (f > 64'sd2147483647) begin
            r.sat = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end else if (f < -64'sd2147483648) begin
            r.sat = 1'b1;
            r.val = 32'h8000_0000;
        end else begin
            r.val = f[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cct_color_matrix_generator_core.sv -----
`default_nettype none

// Colour-temperature to 3x3 correction matrix generator. Load transactions
// (cmd 0) write one Q16.47 coefficient into table table_select, entry
// entry_index, term term_index; loads with entry_index above 8 are dropped,
// and a load is visible to any compute accepted in a later cycle. Compute
// transactions (cmd 1) return one matrix in Q2.30: for color_temp up to
// DIM_STEPS a fade from the identity towards the matrix at the table's native
// temperature, otherwise the cubics at color_temp with the diagonal capped at
// 1.0. A transaction is taken every cycle while the output is not held; a matrix
// is offered once its compute has passed the stages behind the coefficient read:
// three multiply-add Horner steps of two stages each, one subtract stage, eight
// one-byte stages of the fade division, three scale stages, a select stage and
// a rounding stage. Nine lanes, one per matrix entry, run in parallel, each
// with four two-word coefficient RAMs. Coefficients read before they were
// written give undefined results. Write native temperatures only while idle.
module cct_color_matrix_generator_core #(
    parameter int DIM_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic               table_select,
    input  logic [3:0]         entry_index,
    input  logic [1:0]         term_index,
    input  logic signed [63:0] coeff_value,
    input  logic [13:0]        color_temp,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] m00,
    output logic signed [31:0] m01,
    output logic signed [31:0] m02,
    output logic signed [31:0] m10,
    output logic signed [31:0] m11,
    output logic signed [31:0] m12,
    output logic signed [31:0] m20,
    output logic signed [31:0] m21,
    output logic signed [31:0] m22,
    output logic               fade_mode,
    output logic               saturated,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [13:0]        cfg_wdata
);

    import cmg_pkg::*;

    logic [13:0]           native_temp_d65_reg;
    logic [13:0]           native_temp_normal_reg;
    logic [PIPE_DEPTH-1:0] en;
    logic [PIPE_DEPTH-1:0] vld;
    ctl_t [PIPE_DEPTH-1:0] ctl;
    logic                  load_fire;
    logic [TERMS-1:0]      wr_term;
    logic [31:0]           m_val [MATRIX_ENTRIES];
    logic [MATRIX_ENTRIES-1:0] m_sat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            native_temp_d65_reg    <= NATIVE_D65_RST;
            native_temp_normal_reg <= NATIVE_NORMAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NATIVE_D65:    native_temp_d65_reg    <= cfg_wdata;
                CFG_NATIVE_NORMAL: native_temp_normal_reg <= cfg_wdata;
                default:           native_temp_d65_reg    <= native_temp_d65_reg;
            endcase
        end
    end

    cmg_ctrl #(
        .DIM_STEPS(DIM_STEPS)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .cmd               (cmd),
        .table_select      (table_select),
        .color_temp        (color_temp),
        .native_temp_d65   (native_temp_d65_reg),
        .native_temp_normal(native_temp_normal_reg),
        .out_ready         (out_ready),
        .in_ready          (in_ready),
        .en                (en),
        .vld               (vld),
        .ctl               (ctl)
    );

    // Decode a load transaction into a per-term write
    assign load_fire = in_valid && in_ready && (cmd == CMD_LOAD);

    always_comb
    begin
        wr_term = '0;
        wr_term[term_index] = 1'b1;
    end

    for (genvar e = 0; e < MATRIX_ENTRIES; e++)
    begin : g_lane
        cmg_lane #(
            .DIM_STEPS(DIM_STEPS)
        ) u_lane (
            .clk     (clk),
            .diag    (1'((e % 4) == 0)),
            .en      (en),
            .ctl     (ctl),
            .wr_en   ((load_fire && (entry_index == 4'(e))) ? wr_term : '0),
            .wr_table(table_select),
            .wr_data (coeff_value),
            .rd_table(table_select),
            .q       (m_val[e]),
            .sat     (m_sat[e])
        );
    end

    assign m00       = m_val[0];
    assign m01       = m_val[1];
    assign m02       = m_val[2];
    assign m10       = m_val[3];
    assign m11       = m_val[4];
    assign m12       = m_val[5];
    assign m20       = m_val[6];
    assign m21       = m_val[7];
    assign m22       = m_val[8];
    assign saturated = |m_sat;
    assign fade_mode = ctl[PIPE_DEPTH-1].fade;
    assign out_valid = vld[PIPE_DEPTH-1];

    // Input stalls only when every stage is full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled with room in the pipeline");

    // A load transaction never adds or removes a matrix in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (cmd == CMD_LOAD) && !(out_valid && out_ready))
        |=> ($countones(vld) == $past($countones(vld))))
        else $error("load transaction changed pipeline occupancy");

    // A compute transaction adds exactly one matrix in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (cmd == CMD_COMPUTE) && !(out_valid && out_ready))
        |=> ($countones(vld) == $past($countones(vld)) + 1))
        else $error("compute transaction lost or duplicated");

endmodule

`default_nettype wire

// ----- rtl/core/cmg_ram.sv -----
`default_nettype none

module cmg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one word, register the read word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cmg_ctrl.sv -----
`default_nettype none

module cmg_ctrl #(
    parameter int DIM_STEPS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   cmd,
    input  logic                                   table_select,
    input  logic [13:0]                            color_temp,
    input  logic [13:0]                            native_temp_d65,
    input  logic [13:0]                            native_temp_normal,
    input  logic                                   out_ready,
    output logic                                   in_ready,
    output logic [cmg_pkg::PIPE_DEPTH-1:0]         en,
    output logic [cmg_pkg::PIPE_DEPTH-1:0]         vld,
    output cmg_pkg::ctl_t [cmg_pkg::PIPE_DEPTH-1:0] ctl
);

    import cmg_pkg::*;

    logic [PIPE_DEPTH-1:0] vld_reg;
    ctl_t [PIPE_DEPTH-1:0] ctl_reg;
    ctl_t                  ctl_next;

    // Advance a stage when it is empty or the next one advances
    always_comb
    begin
        en = '0;
        en[PIPE_DEPTH-1] = !vld_reg[PIPE_DEPTH-1] || out_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    // Pick the evaluation point and fade step; zero the step off the fade path
    // so the unused scale chain never raises a clamp
    always_comb
    begin
        ctl_next.fade = (color_temp <= 14'(DIM_STEPS));
        ctl_next.s    = ctl_next.fade ? color_temp[7:0] : 8'd0;
        if (ctl_next.fade)
        begin
            ctl_next.x = table_select ? native_temp_d65 : native_temp_normal;
        end
        else
        begin
            ctl_next.x = color_temp;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid && (cmd == CMD_COMPUTE);
            end
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Carry per-transaction control down the pipe
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ctl_reg[0] <= ctl_next;
        end
        for (int k = 1; k < PIPE_DEPTH; k++)
        begin
            if (en[k])
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    assign in_ready = en[0];
    assign vld      = vld_reg;
    assign ctl      = ctl_reg;

endmodule

`default_nettype wire

// ----- rtl/core/cmg_lane.sv -----
`default_nettype none

module cmg_lane #(
    parameter int DIM_STEPS = 16
) (
    input  logic                                   clk,
    input  logic                                   diag,
    input  logic [cmg_pkg::PIPE_DEPTH-1:0]         en,
    input  cmg_pkg::ctl_t [cmg_pkg::PIPE_DEPTH-1:0] ctl,
    input  logic [cmg_pkg::TERMS-1:0]              wr_en,
    input  logic                                   wr_table,
    input  logic [63:0]                            wr_data,
    input  logic                                   rd_table,
    output logic [31:0]                            q,
    output logic                                   sat
);

    import cmg_pkg::*;

    localparam int              DIVK    = 24;
    localparam logic [DIVK:0]   RECIP   = (DIVK+1)'((2**DIVK + DIM_STEPS - 1) / DIM_STEPS);
    localparam logic [7:0]      DIVISOR = 8'(DIM_STEPS);

    logic [63:0] coef [TERMS];

    // Coefficient storage, one word per table for each term
    for (genvar t = 0; t < TERMS; t++)
    begin : g_ram
        cmg_ram #(
            .WIDTH(64),
            .DEPTH(2)
        ) u_ram (
            .clk    (clk),
            .wr_en  (wr_en[t]),
            .wr_addr(wr_table),
            .wr_data(wr_data),
            .rd_en  (en[ST_READ]),
            .rd_addr(rd_table),
            .rd_data(coef[t])
        );
    end

    // ---------------- Horner ----------------
    logic [63:0] c2_s1_reg, c2_s2_reg;
    logic [63:0] c3_s1_reg, c3_s2_reg, c3_s3_reg, c3_s4_reg;

    logic        mul_neg_reg [HORNER_STEPS];
    logic [45:0] mul_lo_reg  [HORNER_STEPS];
    logic [45:0] mul_hi_reg  [HORNER_STEPS];
    sm_t         mul_c_reg   [HORNER_STEPS];
    logic        mul_sat_reg [HORNER_STEPS];
    sm_t         add_reg     [HORNER_STEPS];

    sm_t         acc_in   [HORNER_STEPS];
    logic [63:0] c_in     [HORNER_STEPS];
    logic [45:0] ph       [HORNER_STEPS];
    sm_t         add_next [HORNER_STEPS];

    // Hold the later coefficients until their step
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            c2_s1_reg <= coef[2];
            c3_s1_reg <= coef[3];
        end
        if (en[2])
        begin
            c2_s2_reg <= c2_s1_reg;
            c3_s2_reg <= c3_s1_reg;
        end
        if (en[3])
        begin
            c3_s3_reg <= c3_s2_reg;
        end
        if (en[4])
        begin
            c3_s4_reg <= c3_s3_reg;
        end
    end

    always_comb
    begin
        acc_in[0] = sm_of(coef[0]);
        acc_in[1] = add_reg[0];
        acc_in[2] = add_reg[1];
        c_in[0]   = coef[1];
        c_in[1]   = c2_s2_reg;
        c_in[2]   = c3_s4_reg;
    end

    // Multiply the magnitude by x in two halves
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < HORNER_STEPS; k++)
        begin
            if (en[ST_HORNER + 2*k])
            begin
                mul_lo_reg[k]  <= 46'(acc_in[k].mag[31:0]) * 46'(ctl[ST_HORNER + 2*k - 1].x);
                mul_hi_reg[k]  <= 46'(acc_in[k].mag[63:32]) * 46'(ctl[ST_HORNER + 2*k - 1].x);
                mul_neg_reg[k] <= acc_in[k].neg;
                mul_c_reg[k]   <= sm_of(c_in[k]);
                mul_sat_reg[k] <= acc_in[k].sat;
            end
        end
    end

    // Combine halves, add the next coefficient, saturate
    always_comb
    begin
        for (int k = 0; k < HORNER_STEPS; k++)
        begin
            ph[k] = mul_hi_reg[k] + 46'(mul_lo_reg[k][45:32]);
            add_next[k] = sm_add(mul_neg_reg[k], {ph[k][31:0], mul_lo_reg[k][31:0]},
                                 mul_c_reg[k].neg, mul_c_reg[k].mag);
            if (ph[k][45:32] != 14'd0)
            begin
                add_next[k].neg = mul_neg_reg[k];
                add_next[k].mag = mul_neg_reg[k] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                add_next[k].sat = 1'b1;
            end
            add_next[k].sat = add_next[k].sat | mul_sat_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < HORNER_STEPS; k++)
        begin
            if (en[ST_HORNER + 2*k + 1])
            begin
                add_reg[k] <= add_next[k];
            end
        end
    end

    // ---------------- Fade input and polynomial cap ----------------
    localparam int NF_LEN = ST_SELECT - ST_ONE_MINUS;

    sm_t         p;
    logic [63:0] p_val;
    sm_t         om_p;
    sm_t         t_next;
    logic [63:0] nf_next;
    sm_t         t_reg;
    logic [63:0] nf_reg [NF_LEN];

    always_comb
    begin
        p        = add_reg[HORNER_STEPS-1];
        p_val    = sm_val(p);
        om_p     = sm_add(!p.neg, p.mag, 1'b0, Q47_ONE);
        om_p.sat = om_p.sat | p.sat;
        t_next   = (ctl[ST_ONE_MINUS-1].fade && diag) ? om_p : p;
        nf_next  = (diag && ($signed(p_val) > $signed(Q47_ONE))) ? Q47_ONE : p_val;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_ONE_MINUS])
        begin
            t_reg     <= t_next;
            nf_reg[0] <= nf_next;
        end
        for (int i = 1; i < NF_LEN; i++)
        begin
            if (en[ST_ONE_MINUS + i])
            begin
                nf_reg[i] <= nf_reg[i-1];
            end
        end
    end

    // ---------------- Divide magnitude by DIM_STEPS, a byte a stage ----------------
    logic [63:0] dq_reg [DIV_STEPS];
    logic [7:0]  dr_reg [DIV_STEPS];
    sm_t         dt_reg [DIV_STEPS];

    sm_t         src_t [DIV_STEPS];
    logic [63:0] src_q [DIV_STEPS];
    logic [7:0]  src_r [DIV_STEPS];
    logic [15:0] dv    [DIV_STEPS];
    logic [40:0] dprod [DIV_STEPS];
    logic [7:0]  dqd   [DIV_STEPS];
    logic [7:0]  drem  [DIV_STEPS];
    logic [63:0] dquot [DIV_STEPS];

    always_comb
    begin
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            if (j == 0)
            begin
                src_t[j] = t_reg;
                src_q[j] = 64'd0;
                src_r[j] = 8'd0;
            end
            else
            begin
                src_t[j] = dt_reg[j-1];
                src_q[j] = dq_reg[j-1];
                src_r[j] = dr_reg[j-1];
            end
            dv[j]    = {src_r[j], src_t[j].mag[8*(DIV_STEPS-1-j) +: 8]};
            dprod[j] = 41'(dv[j]) * 41'(RECIP);
            dqd[j]   = dprod[j][DIVK+7:DIVK];
            drem[j]  = 8'(dv[j] - 16'(dqd[j]) * 16'(DIVISOR));
            dquot[j] = src_q[j];
            dquot[j][8*(DIV_STEPS-1-j) +: 8] = dqd[j];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            if (en[ST_DIV_FIRST + j])
            begin
                dq_reg[j] <= dquot[j];
                dr_reg[j] <= drem[j];
                dt_reg[j] <= src_t[j];
            end
        end
    end

    // ---------------- Scale by the fade step ----------------
    logic [39:0] g1_lo_reg, g1_hi_reg, g2_lo_reg, g2_hi_reg;
    logic [15:0] g1_rs_reg;
    logic [7:0]  g2_rsq_reg;
    logic        g1_neg_reg, g1_sat_reg, g2_neg_reg, g2_sat_reg;
    logic [40:0] rs_prod;
    logic [71:0] g_sum;
    sm_t         g3_next;
    sm_t         g3_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_SCALE_MUL])
        begin
            g1_lo_reg  <= 40'(dq_reg[DIV_STEPS-1][31:0]) * 40'(ctl[ST_SCALE_MUL-1].s);
            g1_hi_reg  <= 40'(dq_reg[DIV_STEPS-1][63:32]) * 40'(ctl[ST_SCALE_MUL-1].s);
            g1_rs_reg  <= 16'(dr_reg[DIV_STEPS-1]) * 16'(ctl[ST_SCALE_MUL-1].s);
            g1_neg_reg <= dt_reg[DIV_STEPS-1].neg;
            g1_sat_reg <= dt_reg[DIV_STEPS-1].sat;
        end
    end

    assign rs_prod = 41'(g1_rs_reg) * 41'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en[ST_SCALE_REM])
        begin
            g2_lo_reg  <= g1_lo_reg;
            g2_hi_reg  <= g1_hi_reg;
            g2_rsq_reg <= rs_prod[DIVK+7:DIVK];
            g2_neg_reg <= g1_neg_reg;
            g2_sat_reg <= g1_sat_reg;
        end
    end

    always_comb
    begin
        g_sum       = {g2_hi_reg, 32'd0} + 72'(g2_lo_reg) + 72'(g2_rsq_reg);
        g3_next     = sm_clamp(g2_neg_reg, g_sum[64:0]);
        g3_next.sat = g3_next.sat | g2_sat_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SCALE_SUM])
        begin
            g3_reg <= g3_next;
        end
    end

    // ---------------- Select path and convert ----------------
    sm_t         om_g;
    logic [63:0] h_val_next, h_val_reg;
    logic        h_sat_next, h_sat_reg;
    q_t          qr;
    logic [31:0] q_reg;
    logic        sat_reg;

    always_comb
    begin
        om_g       = sm_add(!g3_reg.neg, g3_reg.mag, 1'b0, Q47_ONE);
        h_val_next = nf_reg[NF_LEN-1];
        h_sat_next = g3_reg.sat;
        if (ctl[ST_SELECT-1].fade)
        begin
            if (diag)
            begin
                h_val_next = sm_val(om_g);
                h_sat_next = g3_reg.sat | om_g.sat;
            end
            else
            begin
                h_val_next = sm_val(g3_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SELECT])
        begin
            h_val_reg <= h_val_next;
            h_sat_reg <= h_sat_next;
        end
    end

    assign qr = to_q230(h_val_reg);

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            q_reg   <= qr.val;
            sat_reg <= h_sat_reg | qr.sat;
        end
    end

    assign q   = q_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire
